FILE: rtl/core/sbm_pkg.sv
// Shared types and constants for the SPI bus monitor.
`timescale 1ns / 1ps

package sbm_pkg;

  // Bits per assembled word on each data line.
  localparam int WORD_BITS = 8;
  // The bit counter must be able to hold WORD_BITS itself.
  localparam int CNT_W = $clog2(WORD_BITS + 1);
  // Working width for taking the low byte of a word of any size.
  localparam int EXT_W = (WORD_BITS > 8) ? WORD_BITS : 8;

  localparam int APB_ADDR_W = 2;
  localparam int APB_DATA_W = 32;
  localparam logic [APB_ADDR_W-1:0] ADDR_SAMPLE_MODE = APB_ADDR_W'(0);

  typedef enum logic [1:0] {
    EV_START = 2'd0,
    EV_WORD  = 2'd1,
    EV_END   = 2'd2
  } event_kind_t;

  typedef struct packed {
    event_kind_t kind;
    logic [7:0]  mosi_byte;
    logic [7:0]  miso_byte;
  } result_t;

endpackage

FILE: rtl/core/spi_bus_monitor.sv
// Top level of the passive SPI bus monitor.
`timescale 1ns / 1ps
//
// The monitor watches an SPI bus one sample at a time. Each transaction on
// the s_* stream carries one sample of the clock, MOSI, MISO and active-low
// select lines. The m_* stream carries events: frame start, a completed
// pair of data-out/data-in words, or frame end; a sample causes at most one.
// The first sample after reset only loads the previous-line registers.
// Inside a frame, the SPI clock edge chosen by sample_mode (rising for
// modes 0 and 3, falling for modes 1 and 2) shifts both data lines in MSB
// first; a partial word is dropped when select rises.
// A sample is processed in the cycle it is accepted; its event is registered
// in the output register, or in the one-entry skid register behind it while
// the receiver stalls. One sample is taken every cycle while the skid entry
// is empty; s_tready falls only when that skid entry is occupied.
// Synchronous reset clears the bus state, the mode register and both output
// entries. sample_mode is written through the APB port; the user must write
// it only while the bus is idle, as the block does not enforce this.
module spi_bus_monitor (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // [0] clock_line, [1] mosi_line, [2] miso_line, [3] select_line, [7:4] zero
  input  logic [7:0]                      s_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // [7:0] mosi_byte, [15:8] miso_byte
  output logic [15:0]                     m_tdata,
  // [1:0] event_kind
  output logic [1:0]                      m_tuser,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [sbm_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [sbm_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [sbm_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready
);
  import sbm_pkg::*;

  logic [1:0]           sample_mode;
  logic                 primed;
  logic                 prev_clock;
  logic                 prev_select;
  logic                 in_frame;
  logic [WORD_BITS-1:0] mosi_shift;
  logic [WORD_BITS-1:0] miso_shift;
  logic [CNT_W-1:0]     bit_count;

  logic                 in_frame_next;
  logic [WORD_BITS-1:0] mosi_shift_next;
  logic [WORD_BITS-1:0] miso_shift_next;
  logic [CNT_W-1:0]     bit_count_next;
  logic                 res_valid;
  result_t              res;

  logic                 out_valid;
  result_t              out_res;
  logic                 skid_valid;
  result_t              skid_res;

  logic clock_line, mosi_line, miso_line, select_line;
  logic accept, take;
  logic sel_fall, sel_rise, rising_mode, clk_edge, word_done;
  logic [WORD_BITS-1:0] mosi_base, miso_base, mosi_sh, miso_sh;
  logic [CNT_W-1:0]     count_base, count_inc;
  logic [EXT_W-1:0]     mosi_ext, miso_ext;

  assign clock_line  = s_tdata[0];
  assign mosi_line   = s_tdata[1];
  assign miso_line   = s_tdata[2];
  assign select_line = s_tdata[3];

  assign s_tready = !skid_valid;
  assign accept   = s_tvalid && s_tready;
  assign take     = out_valid && m_tready;

  assign pready = 1'b1;
  always_comb begin
    prdata = '0;
    if (paddr == ADDR_SAMPLE_MODE) begin
      prdata = APB_DATA_W'(sample_mode);
    end
  end

  always_comb begin
    sel_fall = prev_select && !select_line;
    sel_rise = !prev_select && select_line && in_frame;
    // Modes 0 and 3 have equal bits and sample on the rising edge.
    rising_mode = (sample_mode[0] == sample_mode[1]);
    clk_edge = rising_mode ? (!prev_clock && clock_line) : (prev_clock && !clock_line);

    in_frame_next = sel_fall ? 1'b1 : (sel_rise ? 1'b0 : in_frame);
    mosi_base  = sel_fall ? '0 : mosi_shift;
    miso_base  = sel_fall ? '0 : miso_shift;
    count_base = sel_fall ? '0 : bit_count;

    mosi_sh   = {mosi_base[WORD_BITS-2:0], mosi_line};
    miso_sh   = {miso_base[WORD_BITS-2:0], miso_line};
    count_inc = count_base + CNT_W'(1);
    word_done = in_frame_next && clk_edge && (count_inc == CNT_W'(WORD_BITS));
    mosi_ext  = EXT_W'(mosi_sh);
    miso_ext  = EXT_W'(miso_sh);

    mosi_shift_next = mosi_base;
    miso_shift_next = miso_base;
    bit_count_next  = count_base;
    if (in_frame_next && clk_edge) begin
      if (word_done) begin
        mosi_shift_next = '0;
        miso_shift_next = '0;
        bit_count_next  = '0;
      end else begin
        mosi_shift_next = mosi_sh;
        miso_shift_next = miso_sh;
        bit_count_next  = count_inc;
      end
    end

    res_valid = primed && (sel_fall || sel_rise || word_done);
    res.mosi_byte = '0;
    res.miso_byte = '0;
    priority if (word_done) begin
      res.kind      = EV_WORD;
      res.mosi_byte = mosi_ext[7:0];
      res.miso_byte = miso_ext[7:0];
    end else if (sel_fall) begin
      res.kind = EV_START;
    end else begin
      res.kind = EV_END;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_mode <= '0;
      primed      <= 1'b0;
      prev_clock  <= 1'b0;
      prev_select <= 1'b1;
      in_frame    <= 1'b0;
      mosi_shift  <= '0;
      miso_shift  <= '0;
      bit_count   <= '0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == ADDR_SAMPLE_MODE) begin
        sample_mode <= pwdata[1:0];
      end
      if (accept) begin
        primed      <= 1'b1;
        prev_clock  <= clock_line;
        prev_select <= select_line;
        if (primed) begin
          in_frame   <= in_frame_next;
          mosi_shift <= mosi_shift_next;
          miso_shift <= miso_shift_next;
          bit_count  <= bit_count_next;
        end
      end
    end
  end

  // Output register with a skid entry behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && !take) begin
      if (accept && res_valid) begin
        skid_valid <= 1'b1;
        skid_res   <= res;
      end
    end else if (skid_valid) begin
      out_valid  <= 1'b1;
      out_res    <= skid_res;
      skid_valid <= 1'b0;
    end else begin
      out_valid <= accept && res_valid;
      out_res   <= res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_res.miso_byte, out_res.mosi_byte};
  assign m_tuser  = out_res.kind;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry occupied while output register is empty");

  a_word_on_last_bit: assert property (@(posedge clk) disable iff (rst)
    (accept && res_valid && res.kind == EV_WORD) |-> bit_count == CNT_W'(WORD_BITS - 1))
    else $error("word reported at wrong bit position");

  a_unprimed_no_frame: assert property (@(posedge clk) disable iff (rst)
    !primed |-> (!in_frame && !res_valid))
    else $error("frame activity before the first sample");

  a_count_in_range: assert property (@(posedge clk) disable iff (rst)
    bit_count < CNT_W'(WORD_BITS))
    else $error("bit count reached word size without clearing");

  a_no_data_on_frame_event: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_res.kind != EV_WORD) |-> m_tdata == 16'd0)
    else $error("data bytes nonzero on frame start or end");

endmodule

FILE: tb/sv/tb_spi_bus_monitor.sv
// Self-checking testbench for the SPI bus monitor: line samples in, frame and byte events out.
`timescale 1ns / 1ps

module tb_spi_bus_monitor;
  import sbm_pkg::*;

  localparam int STALL_LIMIT = 1000;
  localparam int RANDOM_SAMPLES = 2000;
  localparam logic [1:0] MODE_0 = 2'd0;
  localparam logic [1:0] MODE_3 = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  // [0] clock_line, [1] mosi_line, [2] miso_line, [3] select_line, [7:4] zero
  logic [7:0]            s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  // [7:0] mosi_byte, [15:8] miso_byte
  logic [15:0]           m_tdata;
  // [1:0] event_kind
  logic [1:0]            m_tuser;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  spi_bus_monitor u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #5 clk = ~clk;

  // Bus state as the monitor should see it.
  logic [1:0]           cur_mode = MODE_0;
  logic                 bus_primed = 1'b0;
  logic                 last_clock = 1'b0;
  logic                 last_select = 1'b1;
  logic                 framing = 1'b0;
  logic [WORD_BITS-1:0] mosi_word = '0;
  logic [WORD_BITS-1:0] miso_word = '0;
  int                   bit_total = 0;

  result_t pending_events[$];
  result_t want;
  int      mismatch_count = 0;
  int      samples_sent = 0;
  int      idle_cycles = 0;
  int      tx_gap_max = 4;
  int      rx_stall_max = 4;

  function automatic result_t make_event(event_kind_t kind, logic [WORD_BITS-1:0] mo,
                                         logic [WORD_BITS-1:0] mi);
    result_t ev;
    logic [EXT_W-1:0] mo_ext;
    logic [EXT_W-1:0] mi_ext;
    mo_ext = EXT_W'(mo);
    mi_ext = EXT_W'(mi);
    ev.kind = kind;
    ev.mosi_byte = (kind == EV_WORD) ? mo_ext[7:0] : 8'h00;
    ev.miso_byte = (kind == EV_WORD) ? mi_ext[7:0] : 8'h00;
    return ev;
  endfunction

  task automatic predict_sample(input logic c, input logic mo, input logic mi, input logic sel);
    logic clk_edge;
    if (!bus_primed) begin
      bus_primed = 1'b1;
      last_clock = c;
      last_select = sel;
      return;
    end
    if (last_select && !sel) begin
      framing = 1'b1;
      bit_total = 0;
      mosi_word = '0;
      miso_word = '0;
      pending_events.push_back(make_event(EV_START, '0, '0));
    end else if (!last_select && sel && framing) begin
      framing = 1'b0;
      pending_events.push_back(make_event(EV_END, '0, '0));
    end
    if (framing) begin
      if (cur_mode == MODE_0 || cur_mode == MODE_3) begin
        clk_edge = !last_clock && c;
      end else begin
        clk_edge = last_clock && !c;
      end
      if (clk_edge) begin
        mosi_word = {mosi_word[WORD_BITS-2:0], mo};
        miso_word = {miso_word[WORD_BITS-2:0], mi};
        bit_total++;
        if (bit_total >= WORD_BITS) begin
          pending_events.push_back(make_event(EV_WORD, mosi_word, miso_word));
          bit_total = 0;
          mosi_word = '0;
          miso_word = '0;
        end
      end
    end
    last_clock = c;
    last_select = sel;
  endtask

  task automatic note_mismatch(input string what, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("mismatch %0d: %s expected 0x%0h actual 0x%0h", mismatch_count, what, exp_v,
               act_v);
    end
  endtask

  // Leaves tvalid high after the transaction so back-to-back samples need no toggle.
  task automatic send_sample(input logic c, input logic mo, input logic mi, input logic sel);
    int gap;
    gap = $urandom_range(0, tx_gap_max);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {4'b0000, sel, mi, mo, c};
    do @(posedge clk); while (!s_tready);
    predict_sample(c, mo, mi, sel);
    samples_sent++;
  endtask

  // Stops the sender and waits until every predicted event has come out.
  task automatic drain_events();
    s_tvalid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic set_mode(input logic [1:0] mode);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_SAMPLE_MODE;
    pwdata <= APB_DATA_W'(mode);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    cur_mode = mode;
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== APB_DATA_W'(mode)) note_mismatch("sample_mode readback", 32'(mode), prdata);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // One frame in the current mode, left open unless close_it; extra_bits adds a partial word.
  task automatic send_frame(input int n_words, input int extra_bits, input bit close_it);
    logic       pre;
    logic [7:0] mo_b;
    logic [7:0] mi_b;
    pre = (cur_mode == MODE_0 || cur_mode == MODE_3) ? 1'b0 : 1'b1;
    send_sample(pre, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b1);
    send_sample(pre, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b0);
    for (int w = 0; w <= n_words; w++) begin
      mo_b = pick_byte();
      mi_b = pick_byte();
      for (int b = 7; b >= 0; b--) begin
        if (w == n_words && (7 - b) >= extra_bits) break;
        send_sample(!pre, mo_b[b], mi_b[b], 1'b0);
        send_sample(pre, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b0);
      end
    end
    if (close_it) send_sample(pre, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b1);
  endtask

  task automatic send_noise(input int len);
    logic [3:0] lines;
    for (int i = 0; i < len; i++) begin
      lines = 4'($urandom_range(0, 15));
      send_sample(lines[0], lines[1], lines[2], lines[3]);
    end
  endtask

  task automatic test_first_sample_priming();
    // Select low on the priming sample must not open a frame; the rise after it is stray.
    send_sample(1'b1, 1'b0, 1'b0, 1'b0);
    send_sample(1'b1, 1'b0, 1'b0, 1'b1);
  endtask

  task automatic test_full_word_extremes();
    // The opening sample carries a rising edge, so it already shifts the first bit.
    send_sample(1'b0, 1'b1, 1'b0, 1'b1);
    send_sample(1'b1, 1'b1, 1'b0, 1'b0);
    repeat (7) begin
      send_sample(1'b0, 1'b0, 1'b1, 1'b0);
      send_sample(1'b1, 1'b1, 1'b0, 1'b0);
    end
    // A clock edge on the closing sample is ignored.
    send_sample(1'b0, 1'b0, 1'b1, 1'b0);
    send_sample(1'b1, 1'b1, 1'b1, 1'b1);
  endtask

  task automatic test_partial_word_dropped();
    send_sample(1'b0, 1'b0, 1'b0, 1'b0);
    send_sample(1'b1, 1'b0, 1'b1, 1'b0);
    send_sample(1'b0, 1'b0, 1'b1, 1'b1);
  endtask

  task automatic test_random_traffic();
    logic [1:0] phase_modes [8] = '{2'd0, 2'd3, 2'd1, 2'd2, 2'd3, 2'd0, 2'd2, 2'd1};
    int phase_end;
    int pick;
    for (int p = 0; p < 8; p++) begin
      drain_events();
      set_mode(phase_modes[p]);
      tx_gap_max = (p == 2 || p == 5) ? 0 : 4;
      rx_stall_max = (p == 2 || p == 6) ? 0 : 4;
      phase_end = samples_sent + RANDOM_SAMPLES / 8;
      while (samples_sent < phase_end) begin
        pick = $urandom_range(0, 9);
        if (pick < 7) begin
          send_frame($urandom_range(1, 4), $urandom_range(0, 3) == 0 ? $urandom_range(1, 7) : 0,
                     1'b1);
        end else if (pick < 9) begin
          send_noise($urandom_range(4, 24));
        end else begin
          send_frame($urandom_range(0, 1), $urandom_range(0, 7), 1'b1);
          send_noise($urandom_range(1, 6));
        end
      end
      // Leave a frame open on odd phases so the next mode takes effect mid-frame.
      if (p % 2 == 1) send_frame(0, $urandom_range(1, 6), 1'b0);
    end
    tx_gap_max = 4;
    rx_stall_max = 4;
    send_frame(2, 0, 1'b1);
  endtask

  // Receiver: draws a stall before each transaction.
  initial begin
    int stall;
    forever begin
      stall = $urandom_range(0, rx_stall_max);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_events.size() == 0) begin
        note_mismatch("unexpected event", 32'h0, {14'h0, m_tuser, m_tdata});
      end else begin
        want = pending_events.pop_front();
        if (m_tuser !== want.kind) note_mismatch("event_kind", 32'(want.kind), 32'(m_tuser));
        if (m_tdata[7:0] !== want.mosi_byte) note_mismatch("mosi_byte", 32'(want.mosi_byte),
                                                            32'(m_tdata[7:0]));
        if (m_tdata[15:8] !== want.miso_byte) note_mismatch("miso_byte", 32'(want.miso_byte),
                                                             32'(m_tdata[15:8]));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || psel || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("tb_spi_bus_monitor NOT OK");
        $finish;
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_first_sample_priming();
    test_full_word_extremes();
    test_partial_word_dropped();
    test_random_traffic();
    drain_events();
    repeat (5) @(posedge clk);
    if (mismatch_count == 0 && pending_events.size() == 0) begin
      $display("tb_spi_bus_monitor OK");
    end else begin
      $display("tb_spi_bus_monitor NOT OK");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/sbm_pkg.sv
rtl/core/spi_bus_monitor.sv
tb/sv/tb_spi_bus_monitor.sv
